// ----- rtl/alarm_snooze_controller_assert.svh -----
// ---------------------------------------------------------------------------
// Alarm snooze controller assertion macros
// Shorthands for clocked concurrent assertions on i_clk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef ALARM_SNOOZE_CONTROLLER_ASSERT_SVH
`define ALARM_SNOOZE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define ASC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alarm_snooze_controller: assertion failed");

// next-cycle implication
`define ASC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alarm_snooze_controller: assertion failed");

`endif

// ----- rtl/asc_pkg.sv -----
// ---------------------------------------------------------------------------
// Alarm snooze controller package
// Field widths, event kinds, register indexes and timing constants.
// ---------------------------------------------------------------------------
package asc_pkg;

    localparam int KIND_W   = 2;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int AUTO_W   = 8;
    localparam int BEEP_W   = 16;
    localparam int RING_W   = 24;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SNOOZE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [IDX_W-1:0] REG_ALARM_HOUR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ALARM_MINUTE = 3'd1;
    localparam logic [IDX_W-1:0] REG_ALARM_EN     = 3'd2;
    localparam logic [IDX_W-1:0] REG_SNOOZE_MIN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_AUTO_STOP    = 3'd4;
    localparam logic [IDX_W-1:0] REG_BEEP_ON      = 3'd5;
    localparam logic [IDX_W-1:0] REG_BEEP_OFF     = 3'd6;

    localparam logic [RING_W-1:0] MS_PER_MINUTE    = 24'd60000;
    localparam logic [6:0]        MINUTES_PER_HOUR = 7'd60;
    localparam logic [6:0]        TWO_HOURS_MIN    = 7'd120;
    localparam logic [5:0]        HOURS_PER_DAY    = 6'd24;

    // reset values
    localparam logic [HOUR_W-1:0]   RST_ALARM_HOUR   = 5'd7;
    localparam logic [MINUTE_W-1:0] RST_ALARM_MINUTE = 6'd0;
    localparam logic [MINUTE_W-1:0] RST_SNOOZE_MIN   = 6'd9;
    localparam logic [AUTO_W-1:0]   RST_AUTO_STOP    = 8'd5;
    localparam logic [BEEP_W-1:0]   RST_BEEP_MS      = 16'd500;
    localparam logic [RING_W-1:0]   RST_STOP_LIMIT   = 24'd300000;

endpackage

// ----- rtl/asc_in_if.sv -----
// ---------------------------------------------------------------------------
// Alarm snooze controller input channel
// Valid/ready channel carrying one event: kind and time of day.
// ---------------------------------------------------------------------------
interface asc_in_if;
    logic                          valid;
    logic                          ready;
    logic [asc_pkg::KIND_W-1:0]    kind;
    logic [asc_pkg::HOUR_W-1:0]    hour;
    logic [asc_pkg::MINUTE_W-1:0]  minute;
    logic [asc_pkg::SECOND_W-1:0]  second;

    modport source (output valid, kind, hour, minute, second, input ready);
    modport sink   (input valid, kind, hour, minute, second, output ready);
endinterface

// ----- rtl/asc_out_if.sv -----
// ---------------------------------------------------------------------------
// Alarm snooze controller result channel
// Valid/ready channel carrying buzzer and ringing status.
// ---------------------------------------------------------------------------
interface asc_out_if;
    logic valid;
    logic ready;
    logic buzzer_on;
    logic ringing;

    modport source (output valid, buzzer_on, ringing, input ready);
    modport sink   (input valid, buzzer_on, ringing, output ready);
endinterface

// ----- rtl/alarm_snooze_controller.sv -----
// ---------------------------------------------------------------------------
// Alarm snooze controller
// Alarm clock with snooze, auto-stop and a programmable beep pattern.
// ---------------------------------------------------------------------------
// One event (ms tick, snooze press or stop press) is taken per clock and each
// gives one status result after it passes through the input register and
// then the result register. The input side keeps taking a
// transfer every cycle while the result side is ready; a stalled result holds
// both registers. All alarm state lives in flops next to the result register,
// so consecutive events see each other's updates without a bubble.
// Registers are at byte addresses 4*i; writing alarm hour, minute or enable
// re-arms the alarm for today. Write registers only while no event is in
// flight.

`include "alarm_snooze_controller_assert.svh"

module alarm_snooze_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    asc_in_if.sink                      i_in,
    asc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [asc_pkg::ADDR_W-1:0]  paddr,
    input  logic [asc_pkg::DATA_W-1:0]  pwdata,
    output logic [asc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // configuration
    logic [asc_pkg::HOUR_W-1:0]   r_alarm_hour;
    logic [asc_pkg::MINUTE_W-1:0] r_alarm_minute;
    logic                         r_en;
    logic [asc_pkg::MINUTE_W-1:0] r_snooze_min;
    logic [asc_pkg::AUTO_W-1:0]   r_auto_stop;
    logic [asc_pkg::RING_W-1:0]   r_stop_limit;
    logic [asc_pkg::BEEP_W-1:0]   r_beep_on;
    logic [asc_pkg::BEEP_W-1:0]   r_beep_off;

    // input register
    logic                         r_s1_valid;
    logic [asc_pkg::KIND_W-1:0]   r_s1_kind;
    logic [asc_pkg::HOUR_W-1:0]   r_s1_hour;
    logic [asc_pkg::MINUTE_W-1:0] r_s1_minute;
    logic [asc_pkg::SECOND_W-1:0] r_s1_second;

    // alarm state
    logic                         r_ring, n_ring;
    logic                         r_fired, n_fired;
    logic                         r_pend, n_pend;
    logic [asc_pkg::HOUR_W-1:0]   r_snz_hour, n_snz_hour;
    logic [asc_pkg::MINUTE_W-1:0] r_snz_minute, n_snz_minute;
    logic [asc_pkg::RING_W-1:0]   r_elapsed, n_elapsed;
    logic [asc_pkg::BEEP_W-1:0]   r_phase_el, n_phase_el;
    logic                         r_beep, n_beep;

    // result register
    logic                         r_out_valid;
    logic                         r_out_buzzer;
    logic                         r_out_ringing;

    logic                         cfg_wr;
    logic [asc_pkg::IDX_W-1:0]    cfg_idx;
    logic                         s1_adv;
    logic                         s1_fire;

    // snooze target
    logic [6:0]                   min_sum;
    logic [5:0]                   min_rem;
    logic [1:0]                   hour_carry;
    logic [5:0]                   hour_sum;
    logic [asc_pkg::HOUR_W-1:0]   tgt_hour;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[asc_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            asc_pkg::REG_ALARM_HOUR:   prdata = asc_pkg::DATA_W'(r_alarm_hour);
            asc_pkg::REG_ALARM_MINUTE: prdata = asc_pkg::DATA_W'(r_alarm_minute);
            asc_pkg::REG_ALARM_EN:     prdata = asc_pkg::DATA_W'(r_en);
            asc_pkg::REG_SNOOZE_MIN:   prdata = asc_pkg::DATA_W'(r_snooze_min);
            asc_pkg::REG_AUTO_STOP:    prdata = asc_pkg::DATA_W'(r_auto_stop);
            asc_pkg::REG_BEEP_ON:      prdata = asc_pkg::DATA_W'(r_beep_on);
            asc_pkg::REG_BEEP_OFF:     prdata = asc_pkg::DATA_W'(r_beep_off);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_hour   <= asc_pkg::RST_ALARM_HOUR;
            r_alarm_minute <= asc_pkg::RST_ALARM_MINUTE;
            r_en           <= 1'b0;
            r_snooze_min   <= asc_pkg::RST_SNOOZE_MIN;
            r_auto_stop    <= asc_pkg::RST_AUTO_STOP;
            r_stop_limit   <= asc_pkg::RST_STOP_LIMIT;
            r_beep_on      <= asc_pkg::RST_BEEP_MS;
            r_beep_off     <= asc_pkg::RST_BEEP_MS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                asc_pkg::REG_ALARM_HOUR:   r_alarm_hour   <= pwdata[asc_pkg::HOUR_W-1:0];
                asc_pkg::REG_ALARM_MINUTE: r_alarm_minute <= pwdata[asc_pkg::MINUTE_W-1:0];
                asc_pkg::REG_ALARM_EN:     r_en           <= pwdata[0];
                asc_pkg::REG_SNOOZE_MIN:   r_snooze_min   <= pwdata[asc_pkg::MINUTE_W-1:0];
                asc_pkg::REG_AUTO_STOP: begin
                    r_auto_stop  <= pwdata[asc_pkg::AUTO_W-1:0];
                    // limit kept in ms so the ringing check is a plain compare
                    r_stop_limit <= asc_pkg::RING_W'(pwdata[asc_pkg::AUTO_W-1:0])
                                    * asc_pkg::MS_PER_MINUTE;
                end
                asc_pkg::REG_BEEP_ON:      r_beep_on      <= pwdata[asc_pkg::BEEP_W-1:0];
                asc_pkg::REG_BEEP_OFF:     r_beep_off     <= pwdata[asc_pkg::BEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: result register frees the input register, which frees the port
    assign s1_adv      = !r_out_valid || o_out.ready;
    assign s1_fire     = r_s1_valid && s1_adv;
    assign i_in.ready  = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_kind   <= i_in.kind;
            r_s1_hour   <= i_in.hour;
            r_s1_minute <= i_in.minute;
            r_s1_second <= i_in.second;
        end
    end

    // current time plus snooze minutes, wrapped at 24 h; minutes overflow by
    // at most two hours, hours by at most one day
    always_comb begin
        min_sum = 7'(r_s1_minute) + 7'(r_snooze_min);
        if (min_sum >= asc_pkg::TWO_HOURS_MIN) begin
            min_rem    = 6'(min_sum - asc_pkg::TWO_HOURS_MIN);
            hour_carry = 2'd2;
        end else if (min_sum >= asc_pkg::MINUTES_PER_HOUR) begin
            min_rem    = 6'(min_sum - asc_pkg::MINUTES_PER_HOUR);
            hour_carry = 2'd1;
        end else begin
            min_rem    = min_sum[5:0];
            hour_carry = 2'd0;
        end
        hour_sum = 6'(r_s1_hour) + 6'(hour_carry);
        if (hour_sum >= asc_pkg::HOURS_PER_DAY) begin
            tgt_hour = asc_pkg::HOUR_W'(hour_sum - asc_pkg::HOURS_PER_DAY);
        end else begin
            tgt_hour = hour_sum[asc_pkg::HOUR_W-1:0];
        end
    end

    always_comb begin
        logic                        sec_zero;
        logic                        snz_hit;
        logic                        started;
        logic [asc_pkg::BEEP_W-1:0]  len;
        logic [asc_pkg::BEEP_W-1:0]  ph;

        n_ring       = r_ring;
        n_fired      = r_fired;
        n_pend       = r_pend;
        n_snz_hour   = r_snz_hour;
        n_snz_minute = r_snz_minute;
        n_elapsed    = r_elapsed;
        n_phase_el   = r_phase_el;
        n_beep       = r_beep;
        sec_zero     = (r_s1_second == '0);
        snz_hit      = 1'b0;
        started      = 1'b0;
        len          = '0;
        ph           = '0;

        case (r_s1_kind)
            asc_pkg::KIND_TICK: begin
                if (r_en) begin
                    if (r_s1_hour == '0 && r_s1_minute == '0 && sec_zero) begin
                        n_fired = 1'b0;
                        n_pend  = 1'b0;
                    end
                    snz_hit = n_pend && r_s1_hour == r_snz_hour
                              && r_s1_minute == r_snz_minute && sec_zero;
                    if (snz_hit) begin
                        n_pend  = 1'b0;
                        n_fired = 1'b0;
                    end
                    if (!r_ring && sec_zero && (snz_hit || (!n_fired
                            && r_s1_hour == r_alarm_hour
                            && r_s1_minute == r_alarm_minute))) begin
                        n_ring     = 1'b1;
                        n_fired    = 1'b1;
                        n_elapsed  = '0;
                        n_phase_el = '1;
                        n_beep     = 1'b0;
                        started    = 1'b1;
                    end
                    if (n_ring) begin
                        if (!started && n_elapsed != '1) begin
                            n_elapsed = n_elapsed + 1'b1;
                        end
                        if (n_elapsed > r_stop_limit) begin
                            n_ring = 1'b0;
                            n_beep = 1'b0;
                        end else begin
                            len = n_beep ? r_beep_on : r_beep_off;
                            ph  = (n_phase_el != '1) ? n_phase_el + 1'b1 : n_phase_el;
                            if (ph >= len) begin
                                n_beep     = !n_beep;
                                n_phase_el = '0;
                            end else begin
                                n_phase_el = ph;
                            end
                        end
                    end
                end
            end
            asc_pkg::KIND_SNOOZE: begin
                if (r_ring) begin
                    n_ring       = 1'b0;
                    n_beep       = 1'b0;
                    n_snz_hour   = tgt_hour;
                    n_snz_minute = min_rem;
                    n_pend       = 1'b1;
                    n_fired      = 1'b1;
                end
            end
            asc_pkg::KIND_STOP: begin
                n_ring = 1'b0;
                n_beep = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring       <= 1'b0;
            r_fired      <= 1'b0;
            r_pend       <= 1'b0;
            r_snz_hour   <= '0;
            r_snz_minute <= '0;
            r_elapsed    <= '0;
            r_phase_el   <= '1;
            r_beep       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_ring       <= n_ring;
                r_fired      <= n_fired;
                r_pend       <= n_pend;
                r_snz_hour   <= n_snz_hour;
                r_snz_minute <= n_snz_minute;
                r_elapsed    <= n_elapsed;
                r_phase_el   <= n_phase_el;
                r_beep       <= n_beep;
            end else if (cfg_wr && (cfg_idx == asc_pkg::REG_ALARM_HOUR
                    || cfg_idx == asc_pkg::REG_ALARM_MINUTE
                    || cfg_idx == asc_pkg::REG_ALARM_EN)) begin
                // alarm re-armed for today
                r_fired <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_buzzer  <= n_ring & n_beep;
            r_out_ringing <= n_ring;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.buzzer_on = r_out_buzzer;
    assign o_out.ringing   = r_out_ringing;

    `ASC_ASSERT_NOW(a_beep_only_when_ringing, !r_ring, !r_beep)
    `ASC_ASSERT_NEXT(a_snooze_arms_target,
        s1_fire && r_s1_kind == asc_pkg::KIND_SNOOZE && r_ring,
        r_pend && r_fired && !r_ring)
    `ASC_ASSERT_NEXT(a_stop_halts, s1_fire && r_s1_kind == asc_pkg::KIND_STOP,
        !r_ring && !r_beep)
    `ASC_ASSERT_NEXT(a_disabled_tick_frozen,
        s1_fire && r_s1_kind == asc_pkg::KIND_TICK && !r_en,
        $stable(r_ring) && $stable(r_elapsed) && $stable(r_phase_el))

endmodule
